>>> hw/rtl/oplp_pkg.sv
// oplp_pkg: shared types and constants for the register dump player
// no dependencies; used by the interfaces and the top level
package oplp_pkg;

  localparam int MAP_ENTRIES_DEF   = 128;
  localparam int POSITION_BITS_DEF = 24;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int LENGTH_W    = 24;
  localparam int OUT_POS_W   = 24;
  localparam int DELAY_W     = 25;
  localparam int MS_UNITS_W  = 17;

  localparam logic [MS_UNITS_W-1:0] UNITS_PER_MS   = 17'd441;
  localparam logic [DELAY_W-1:0]    UNITS_PER_TICK = 25'd10;
  localparam logic [15:0]           MIN_VERSION    = 16'd2;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_MAP_WRITE = 2'd1,
    OP_START     = 2'd2,
    OP_STOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_VERSION = 2'd1,
    ST_FORMAT  = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VERSION_MAJOR    = 3'd0,
    CFG_FORMAT_CODE      = 3'd1,
    CFG_COMPRESSION_CODE = 3'd2,
    CFG_SHORT_DELAY_CODE = 3'd3,
    CFG_LONG_DELAY_CODE  = 3'd4,
    CFG_LENGTH_PAIRS     = 3'd5,
    CFG_LOOP_COUNT       = 3'd6
  } cfg_index_t;

endpackage

>>> hw/rtl/oplp_if.sv
// oplp_if: valid/ready channel interfaces for input, result and configuration transactions
// depends on oplp_pkg
interface oplp_in_if;
  logic            valid;
  logic            ready;
  oplp_pkg::op_t   operation;
  logic [7:0]      pair_reg;
  logic [7:0]      pair_val;
  logic [6:0]      map_index;
  logic [7:0]      map_entry;
  logic            from_beginning;

  modport source (output valid, operation, pair_reg, pair_val, map_index, map_entry,
                  from_beginning, input ready);
  modport sink (input valid, operation, pair_reg, pair_val, map_index, map_entry,
                from_beginning, output ready);
endinterface

interface oplp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             write_valid;
  logic [8:0]                       write_address;
  logic [7:0]                       write_data;
  logic                             pair_taken;
  logic [oplp_pkg::OUT_POS_W-1:0]   next_position;
  logic                             playing;
  oplp_pkg::status_t                start_status;

  modport source (output valid, write_valid, write_address, write_data, pair_taken,
                  next_position, playing, start_status, input ready);
  modport sink (input valid, write_valid, write_address, write_data, pair_taken,
                next_position, playing, start_status, output ready);
endinterface

interface oplp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [oplp_pkg::CFG_INDEX_W-1:0]  index;
  logic [oplp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/oplp_ram.sv
// oplp_ram: generic single write port ram with one registered read port
// no dependencies
module oplp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/opl_register_dump_player.sv
// opl_register_dump_player: register dump playback with delay counting and code map lookup
// depends on oplp_pkg, oplp_if and oplp_ram
// pipeline: input stage with map read, then result register
// throughput: one transaction per cycle, limited only by the result side taking results
// reset: synchronous active low; clears playback state and loads register defaults,
// code map contents stay undefined until written, no clearing pass
module opl_register_dump_player #(
  parameter int MAP_ENTRIES   = oplp_pkg::MAP_ENTRIES_DEF,
  parameter int POSITION_BITS = oplp_pkg::POSITION_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  oplp_in_if.sink   in_ch,
  oplp_out_if.source out_ch,
  oplp_cfg_if.sink  cfg_ch
);

  localparam int MAP_AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CMP_W  = (POSITION_BITS > oplp_pkg::LENGTH_W) ? POSITION_BITS
                                                               : oplp_pkg::LENGTH_W;
  localparam logic [7:0] MAP_LIMIT = 8'(MAP_ENTRIES);

  // configuration registers
  logic [15:0]                   version_r;
  logic [7:0]                    format_r;
  logic [7:0]                    compression_r;
  logic [7:0]                    short_code_r;
  logic [7:0]                    long_code_r;
  logic [oplp_pkg::LENGTH_W-1:0] length_r;
  logic signed [7:0]             loop_count_r;

  // playback state
  logic                         enabled_r, enabled_nxt;
  logic [oplp_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic [POSITION_BITS-1:0]     pos_r, pos_nxt;
  logic [7:0]                   loops_r, loops_nxt;

  // input stage
  logic          s1_valid_r;
  oplp_pkg::op_t s1_op_r;
  logic [7:0]    s1_reg_r;
  logic [7:0]    s1_val_r;
  logic          s1_fromb_r;
  logic          s1_hit_r;

  // result stage
  logic              out_valid_r;
  logic              wv_r, wv_nxt;
  logic [8:0]        wa_r, wa_nxt;
  logic [7:0]        wd_r, wd_nxt;
  logic              taken_r, taken_nxt;
  oplp_pkg::status_t status_r, status_nxt;

  logic       accept;
  logic       s1_fire;
  logic       map_we;
  logic [7:0] map_rdata;
  logic [7:0] ent;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign map_we = accept && (in_ch.operation == oplp_pkg::OP_MAP_WRITE)
                  && ({1'b0, in_ch.map_index} < MAP_LIMIT);

  oplp_ram #(
    .WIDTH (8),
    .DEPTH (MAP_ENTRIES)
  ) u_code_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_ch.map_index[MAP_AW-1:0]),
    .wdata (in_ch.map_entry),
    .re    (accept),
    .raddr (in_ch.pair_reg[MAP_AW-1:0]),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r     <= 16'd2;
      format_r      <= 8'd0;
      compression_r <= 8'd0;
      short_code_r  <= 8'd0;
      long_code_r   <= 8'd1;
      length_r      <= '0;
      loop_count_r  <= 8'sd1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        oplp_pkg::CFG_VERSION_MAJOR:    version_r     <= cfg_ch.data[15:0];
        oplp_pkg::CFG_FORMAT_CODE:      format_r      <= cfg_ch.data[7:0];
        oplp_pkg::CFG_COMPRESSION_CODE: compression_r <= cfg_ch.data[7:0];
        oplp_pkg::CFG_SHORT_DELAY_CODE: short_code_r  <= cfg_ch.data[7:0];
        oplp_pkg::CFG_LONG_DELAY_CODE:  long_code_r   <= cfg_ch.data[7:0];
        oplp_pkg::CFG_LENGTH_PAIRS:     length_r      <= cfg_ch.data[oplp_pkg::LENGTH_W-1:0];
        oplp_pkg::CFG_LOOP_COUNT:       loop_count_r  <= signed'(cfg_ch.data[7:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      enabled_r   <= 1'b0;
      delay_r     <= '0;
      pos_r       <= '0;
      loops_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        enabled_r   <= enabled_nxt;
        delay_r     <= delay_nxt;
        pos_r       <= pos_nxt;
        loops_r     <= loops_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_ch.operation;
      s1_reg_r   <= in_ch.pair_reg;
      s1_val_r   <= in_ch.pair_val;
      s1_fromb_r <= in_ch.from_beginning;
      s1_hit_r   <= ({1'b0, in_ch.pair_reg[6:0]} < MAP_LIMIT);
    end
    if (s1_fire) begin
      wv_r     <= wv_nxt;
      wa_r     <= wa_nxt;
      wd_r     <= wd_nxt;
      taken_r  <= taken_nxt;
      status_r <= status_nxt;
    end
  end

  assign ent = s1_hit_r ? map_rdata : 8'd0;

  always_comb begin
    logic [8:0]                      ms;
    logic [oplp_pkg::MS_UNITS_W-1:0] units;
    logic [POSITION_BITS-1:0]        pos_inc;
    logic [7:0]                      loops_dec;
    logic                            pass_end;

    ms        = {1'b0, s1_val_r} + 9'd1;
    units     = oplp_pkg::MS_UNITS_W'({8'd0, ms} * oplp_pkg::UNITS_PER_MS);
    pos_inc   = pos_r + POSITION_BITS'(1);
    loops_dec = loops_r - 8'd1;
    pass_end  = CMP_W'(pos_inc) >= CMP_W'(length_r);

    enabled_nxt = enabled_r;
    delay_nxt   = delay_r;
    pos_nxt     = pos_r;
    loops_nxt   = loops_r;
    wv_nxt      = 1'b0;
    wa_nxt      = '0;
    wd_nxt      = '0;
    taken_nxt   = 1'b0;
    status_nxt  = oplp_pkg::ST_OK;

    case (s1_op_r)
      oplp_pkg::OP_MAP_WRITE: ;
      oplp_pkg::OP_START: begin
        if (version_r < oplp_pkg::MIN_VERSION) begin
          status_nxt = oplp_pkg::ST_VERSION;
        end else if (format_r != 8'd0 || compression_r != 8'd0) begin
          status_nxt = oplp_pkg::ST_FORMAT;
        end
        enabled_nxt = (status_nxt == oplp_pkg::ST_OK);
        delay_nxt   = '0;
        loops_nxt   = unsigned'(loop_count_r);
        if (s1_fromb_r) begin
          pos_nxt = '0;
        end
      end
      oplp_pkg::OP_STOP: begin
        enabled_nxt = 1'b0;
      end
      oplp_pkg::OP_TICK: begin
        if (enabled_r) begin
          if (delay_r != '0) begin
            delay_nxt = (delay_r > oplp_pkg::UNITS_PER_TICK)
                        ? delay_r - oplp_pkg::UNITS_PER_TICK : '0;
          end else begin
            taken_nxt = 1'b1;
            if (s1_reg_r == short_code_r) begin
              delay_nxt = oplp_pkg::DELAY_W'(units);
            end else if (s1_reg_r == long_code_r) begin
              delay_nxt = {units, 8'd0};
            end else begin
              wv_nxt = 1'b1;
              wa_nxt = {s1_reg_r[7], ent};
              wd_nxt = s1_val_r;
            end
            pos_nxt = pos_inc;
            if (pass_end) begin
              pos_nxt   = '0;
              loops_nxt = loops_dec;
              if (loops_dec == 8'd0) begin
                enabled_nxt = 1'b0;
              end else if (loops_dec[7]) begin
                loops_nxt = 8'hff;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_valid   = wv_r;
  assign out_ch.write_address = wa_r;
  assign out_ch.write_data    = wd_r;
  assign out_ch.pair_taken    = taken_r;
  assign out_ch.next_position = oplp_pkg::OUT_POS_W'(pos_r);
  assign out_ch.playing       = enabled_r;
  assign out_ch.start_status  = status_r;

  a_write_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && wv_r |-> taken_r)
    else $error("chip write without a consumed pair");

  a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !wv_r |-> (wa_r == 9'd0) && (wd_r == 8'd0))
    else $error("write fields not cleared without a write");

  a_refused_start_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != oplp_pkg::ST_OK) |-> !enabled_r)
    else $error("playback enabled after a refused start");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input held off without a full pipeline");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(pos_r) && $stable(delay_r) && $stable(loops_r))
    else $error("playback state moved without a transaction");

endmodule
